// ----- rtl/wcc_pkg.sv -----
// ---------------------------------------------------------------------------
// wcc_pkg
// Shared types and constants for the windowed co-occurrence counter.
// ---------------------------------------------------------------------------
package wcc_pkg;

    localparam int VOCAB    = 4096;
    localparam int LAYER    = 64;
    localparam int WORD_W   = 12;
    localparam int HASH_W   = 32;
    localparam int COLIN_W  = 6;
    localparam int COUNT_W  = 32;
    localparam int WIN_W    = 4;
    localparam logic [WIN_W-1:0] WINDOW_RESET = 4'd5;

    localparam logic OP_WORD = 1'b0;
    localparam logic OP_READ = 1'b1;

    // request from the control sequencer to the count store
    typedef struct packed {
        logic        valid;
        logic        is_read;
        logic [31:0] addr;
        logic [31:0] inc;
    } store_req_t;

endpackage

// ----- rtl/windowed_cooccurrence_counter.sv -----
// ---------------------------------------------------------------------------
// windowed_cooccurrence_counter
// Sliding-window weighted co-occurrence counts in a saturating count memory.
// ---------------------------------------------------------------------------
// channel | dir | transfer carries
// s_      | in  | tuser=op, tdata={read_column,read_row,sentence_start,hash,word_id}
// m_      | out | tdata=count_value
// cfg_    | in  | window_size
//
// A word does two memory read-modify-writes per neighbor counted (w =
// neighbors counted), one after the other on the single store port; the
// next transfer is accepted only once they are done. A read loads the output
// register from the store's registered read data. After reset a clearing pass
// zeroes all VOCAB*LAYER words (262144 by default) before s_tready rises.
// A finished count waits in the output register; a new transfer is taken
// only once it has been drained.
module windowed_cooccurrence_counter #(
    parameter int MAX_WINDOW    = 15,
    parameter int FRACTION_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic         s_tuser,            // op
    input  logic [63:0]  s_tdata,            // word_id, word_hash, sentence_start,
                                             // read_row, read_column
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,            // count_value
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [3:0]   cfg_data            // window_size
);
    localparam int ROW_W = $clog2(wcc_pkg::VOCAB);
    localparam int COL_W = $clog2(wcc_pkg::LAYER);

    logic [3:0] win_reg;
    logic       s_xfer, idle, busy, clearing, rd_valid, out_v_reg;
    logic [31:0] out_d_reg, rd_data;
    wcc_pkg::store_req_t req;

    assign s_tready  = idle && !clearing && !out_v_reg;
    assign s_xfer    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    wcc_seq #(.ROW_W(ROW_W), .COL_W(COL_W), .MAXW(MAX_WINDOW),
              .FRAC(FRACTION_BITS)) u_seq (
        .aclk(aclk), .aresetn(aresetn), .start(s_xfer), .op(s_tuser),
        .word_id(s_tdata[11:0]), .word_hash(s_tdata[43:12]),
        .sentence_start(s_tdata[44]), .read_row(s_tdata[56:45]),
        .read_column(s_tdata[62:57]), .window(win_reg),
        .store_busy(busy), .req(req), .idle(idle)
    );

    wcc_store #(.ADDR_W(ROW_W + COL_W)) u_store (
        .aclk(aclk), .aresetn(aresetn), .req(req), .busy(busy),
        .clearing(clearing), .rd_valid(rd_valid), .rd_data(rd_data)
    );

    always_ff @(posedge aclk) begin
        if (rd_valid) out_d_reg <= rd_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg   <= wcc_pkg::WINDOW_RESET;
            out_v_reg <= 1'b0;
        end else begin
            if (cfg_valid) win_reg <= cfg_data;
            if (rd_valid) out_v_reg <= 1'b1;
            else if (m_tready) out_v_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_d_reg;
endmodule

// ----- rtl/wcc_store.sv -----
// ---------------------------------------------------------------------------
// wcc_store
// Count memory with saturating read-modify-write and a clearing pass.
// ---------------------------------------------------------------------------
module wcc_store #(
    parameter int ADDR_W = 18
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  wcc_pkg::store_req_t           req,
    output logic                          busy,
    output logic                          clearing,
    output logic                          rd_valid,
    output logic [wcc_pkg::COUNT_W-1:0]   rd_data
);
    localparam int DEPTH = 1 << ADDR_W;

    logic [wcc_pkg::COUNT_W-1:0] mem [DEPTH];
    logic [wcc_pkg::COUNT_W-1:0] q_reg;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic              clr_on_reg, clr_on_next;
    // stage 1: read issued; stage 2: data present, write back
    logic              s1_reg, s1_rd_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [31:0]       s1_inc_reg;
    logic [wcc_pkg::COUNT_W:0] sum;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [wcc_pkg::COUNT_W-1:0] wr_data;

    assign sum = {1'b0, q_reg} + {1'b0, s1_inc_reg};

    always_comb begin
        clr_next    = clr_reg;
        clr_on_next = clr_on_reg;
        wr_en   = 1'b0;
        wr_addr = s1_addr_reg;
        wr_data = sum[wcc_pkg::COUNT_W] ? '1 : sum[wcc_pkg::COUNT_W-1:0];
        if (clr_on_reg) begin
            wr_en   = 1'b1;
            wr_addr = clr_reg;
            wr_data = '0;
            clr_next = clr_reg + 1'b1;
            if (&clr_reg) clr_on_next = 1'b0;
        end else if (s1_reg && !s1_rd_reg) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        q_reg <= mem[req.addr[ADDR_W-1:0]];
        s1_addr_reg <= req.addr[ADDR_W-1:0];
        s1_inc_reg  <= req.inc;
        s1_rd_reg   <= req.is_read;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg    <= '0;
            clr_on_reg <= 1'b1;
            s1_reg     <= 1'b0;
        end else begin
            clr_reg    <= clr_next;
            clr_on_reg <= clr_on_next;
            s1_reg     <= req.valid;
        end
    end

    // sequencer holds off while busy is high, so write-back precedes next read
    assign busy     = s1_reg;
    assign clearing = clr_on_reg;
    assign rd_valid = s1_reg && s1_rd_reg;
    assign rd_data  = q_reg;
endmodule

// ----- rtl/wcc_seq.sv -----
// ---------------------------------------------------------------------------
// wcc_seq
// History ring and per-neighbor update sequencer.
// ---------------------------------------------------------------------------
module wcc_seq #(
    parameter int ROW_W  = 12,
    parameter int COL_W  = 6,
    parameter int MAXW   = 15,
    parameter int FRAC   = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic                        op,
    input  logic [wcc_pkg::WORD_W-1:0]  word_id,
    input  logic [wcc_pkg::HASH_W-1:0]  word_hash,
    input  logic                        sentence_start,
    input  logic [wcc_pkg::WORD_W-1:0]  read_row,
    input  logic [wcc_pkg::COLIN_W-1:0] read_column,
    input  logic [wcc_pkg::WIN_W-1:0]   window,
    input  logic                        store_busy,
    output wcc_pkg::store_req_t         req,
    output logic                        idle
);
    localparam int HW = (MAXW > 1) ? $clog2(MAXW) : 1;
    localparam int CW = $clog2(MAXW + 1);
    localparam logic [1:0] S_IDLE = 2'd0, S_A = 2'd1, S_B = 2'd2;

    logic [ROW_W-1:0] hw_mem [MAXW];
    logic [COL_W-1:0] hc_mem [MAXW];
    logic [CW-1:0] fill_reg, fill_next, d_reg, d_next, win_reg, win_next;
    logic [HW-1:0] head_reg, head_next, slot_reg, slot_next;
    logic [1:0]    st_reg, st_next;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_reg;
    logic [31:0]   w_q;
    logic [CW-1:0] wcl;
    logic [HW-1:0] h0;
    logic [CW-1:0] f0;
    logic          hist_we;

    // weight table round(2^FRAC/d)
    function automatic logic [31:0] weight(input logic [CW-1:0] d);
        logic [63:0] n;
        n = 64'd1 << (FRAC + 1);
        weight = 32'd0;
        for (int k = 1; k <= MAXW; k++)
            if (d == CW'(k)) weight = 32'((n / 64'(k) + 64'd1) >> 1);
    endfunction

    assign w_q = weight(d_reg);

    always_comb begin
        st_next = st_reg; fill_next = fill_reg; head_next = head_reg;
        d_next = d_reg; win_next = win_reg; slot_next = slot_reg;
        req = '0; hist_we = 1'b0;
        h0 = sentence_start ? '0 : head_reg;
        f0 = sentence_start ? '0 : fill_reg;
        wcl = (32'(window) > MAXW) ? CW'(MAXW) : CW'(window);
        if (wcl > f0) wcl = f0;
        case (st_reg)
            S_IDLE: begin
                if (start && op == wcc_pkg::OP_READ) begin
                    req.valid = 1'b1; req.is_read = 1'b1;
                    req.addr = 32'(read_row[ROW_W-1:0]) * (32'd1 << COL_W)
                             + 32'(read_column[COL_W-1:0]);
                end else if (start) begin
                    head_next = h0; fill_next = f0; win_next = wcl;
                    d_next = CW'(1);
                    slot_next = (h0 == '0) ? HW'(MAXW - 1) : h0 - 1'b1;
                    if (wcl != '0) st_next = S_A;
                    else hist_we = 1'b1;
                end
            end
            S_A: if (!store_busy) begin
                req.valid = 1'b1; req.inc = w_q;
                req.addr = 32'(row_reg) * (32'd1 << COL_W) + 32'(hc_mem[slot_reg]);
                st_next = S_B;
            end
            S_B: if (!store_busy) begin
                req.valid = 1'b1; req.inc = w_q;
                req.addr = 32'(hw_mem[slot_reg]) * (32'd1 << COL_W) + 32'(col_reg);
                if (d_reg == win_reg) begin
                    st_next = S_IDLE; hist_we = 1'b1;
                end else begin
                    st_next = S_A; d_next = d_reg + 1'b1;
                    slot_next = (slot_reg == '0) ? HW'(MAXW - 1) : slot_reg - 1'b1;
                end
            end
            default: st_next = S_IDLE;
        endcase
        if (hist_we) begin
            head_next = (head_next == HW'(MAXW - 1)) ? '0 : head_next + 1'b1;
            if (fill_next < CW'(MAXW)) fill_next = fill_next + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (st_reg == S_IDLE && start) begin
            row_reg <= word_id[ROW_W-1:0];
            col_reg <= word_hash[COL_W-1:0];
        end
        if (hist_we) begin
            hw_mem[(st_reg == S_IDLE) ? h0 : head_reg] <=
                (st_reg == S_IDLE) ? word_id[ROW_W-1:0] : row_reg;
            hc_mem[(st_reg == S_IDLE) ? h0 : head_reg] <=
                (st_reg == S_IDLE) ? word_hash[COL_W-1:0] : col_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_IDLE; fill_reg <= '0; head_reg <= '0;
            d_reg <= '0; win_reg <= '0; slot_reg <= '0;
        end else begin
            st_reg <= st_next; fill_reg <= fill_next; head_reg <= head_next;
            d_reg <= d_next; win_reg <= win_next; slot_reg <= slot_next;
        end
    end

    assign idle = (st_reg == S_IDLE) && !store_busy;
endmodule

// ----- rtl/wcc_checker.sv -----
// ---------------------------------------------------------------------------
// wcc_checker
// Port-level checks for the co-occurrence counter.
// ---------------------------------------------------------------------------
module wcc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("hold");
    a_noacc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("accept with pending result");
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid) else $error("reset");
endmodule

bind windowed_cooccurrence_counter wcc_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the windowed co-occurrence counter: words and
// count reads are streamed in, a local count model predicts every read.
// ---------------------------------------------------------------------------

class cooc_scoreboard;
    localparam int ROWS = 4096;
    localparam int COLS = 64;
    localparam int MAXW = 15;

    logic [31:0] counts [ROWS*COLS];
    logic [11:0] hist_row [MAXW];
    logic [5:0]  hist_col [MAXW];
    int unsigned fill;
    int unsigned head;
    logic [3:0]  window;
    logic [31:0] pending_counts [$];
    int          errors;
    int          reads_checked;

    function new();
        foreach (counts[i]) counts[i] = '0;
        fill = 0;
        head = 0;
        window = wcc_pkg::WINDOW_RESET;
        errors = 0;
        reads_checked = 0;
    endfunction

    function void set_window(logic [3:0] w);
        window = w;
    endfunction

    // round(2^16 / d), ties up
    function logic [31:0] weight(int unsigned d);
        return ((32'd1 << 17) / d + 1) >> 1;
    endfunction

    function void bump(logic [11:0] r, logic [5:0] c, logic [31:0] inc);
        logic [32:0] sum;
        sum = {1'b0, counts[r*COLS + c]} + {1'b0, inc};
        counts[r*COLS + c] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    function void note_input(logic op, logic [63:0] d);
        logic [11:0] r;
        logic [5:0]  c;
        int unsigned w;
        int unsigned slot;
        if (op == wcc_pkg::OP_READ) begin
            pending_counts.push_back(counts[d[56:45]*COLS + d[62:57]]);
            return;
        end
        r = d[11:0];
        c = d[17:12];
        if (d[44]) begin
            fill = 0;
            head = 0;
        end
        w = (window > MAXW) ? MAXW : window;
        if (w > fill) w = fill;
        for (int unsigned k = 1; k <= w; k++) begin
            slot = (head + MAXW - k) % MAXW;
            bump(r, hist_col[slot], weight(k));
            bump(hist_row[slot], c, weight(k));
        end
        hist_row[head] = r;
        hist_col[head] = c;
        head = (head + 1) % MAXW;
        if (fill < MAXW) fill++;
    endfunction

    function void check_result(logic [31:0] got);
        logic [31:0] exp_v;
        if (pending_counts.size() == 0) begin
            $error("count_value: unexpected result %h", got);
            errors++;
            return;
        end
        exp_v = pending_counts.pop_front();
        reads_checked++;
        if (got !== exp_v) begin
            $error("count_value: expected %h, got %h", exp_v, got);
            errors++;
        end
    endfunction
endclass

module tb_top;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic        s_tuser = 1'b0;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [3:0]  cfg_data = '0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int words_sent = 0;
    int reads_sent = 0;

    cooc_scoreboard sb = new();

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    windowed_cooccurrence_counter dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // receiver: random stalls
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // outputs are settled at the falling edge; a handshake seen here
    // completes at the next rising edge
    always @(negedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // one transfer on the input stream, with random idle cycles ahead of it
    task automatic send_item(logic op, logic [63:0] d);
        logic rdy;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= d;
        do begin
            @(negedge aclk);
            rdy = s_tready;
            @(posedge aclk);
        end while (!rdy);
        sb.note_input(op, d);
        if (op == wcc_pkg::OP_READ) reads_sent++; else words_sent++;
    endtask

    // tdata: word_id[11:0] hash[43:12] start[44] row[56:45] col[62:57]
    task automatic send_word(logic [11:0] id, logic [31:0] h, logic st);
        send_item(wcc_pkg::OP_WORD, {7'd0, 6'd0, 12'd0, st, h, id});
    endtask

    task automatic send_read(logic [11:0] r, logic [5:0] c);
        send_item(wcc_pkg::OP_READ, {1'b0, c, r, 1'b0, 32'd0, 12'd0});
    endtask

    // drain outstanding reads, then let a word in flight finish
    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        while (sb.pending_counts.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic write_window(logic [3:0] w);
        wait_quiet();
        cfg_valid <= 1'b1;
        cfg_data  <= w;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.set_window(w);
        cfg_valid <= 1'b0;
    endtask

    // small vocabulary subsets so reads hit populated counts
    task automatic random_phase(int n, logic [3:0] w);
        logic [11:0] rows [8];
        logic [5:0]  cols [8];
        logic [31:0] hashes [8];
        int k;
        write_window(w);
        foreach (rows[i]) begin
            rows[i]   = 12'($urandom_range(4095));
            hashes[i] = $urandom;
            cols[i]   = hashes[i][5:0];
        end
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(7);
            if ($urandom_range(99) < 35) begin
                if ($urandom_range(9) == 0)
                    send_read(12'($urandom_range(4095)), 6'($urandom_range(63)));
                else send_read(rows[k], cols[$urandom_range(7)]);
            end else if ($urandom_range(9) == 0) begin
                send_word(12'($urandom_range(4095)), $urandom, $urandom_range(19) == 0);
            end else begin
                send_word(rows[k], hashes[k], $urandom_range(24) == 0);
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: field extremes, sentence restarts, default window
        send_word(12'd0, 32'h0000_0000, 1'b1);
        send_word(12'hFFF, 32'hFFFF_FFFF, 1'b0);
        send_word(12'd0, 32'h8000_003F, 1'b0);
        send_read(12'd0, 6'd63);
        send_read(12'hFFF, 6'd0);
        send_read(12'd0, 6'd0);
        send_word(12'd5, 32'h5555_5555, 1'b1);
        send_word(12'hAAA, 32'hAAAA_AAAA, 1'b0);
        send_read(12'd5, 6'h2A);
        send_read(12'hAAA, 6'h15);
        // window zero: history grows, nothing counted
        write_window(4'd0);
        send_word(12'd7, 32'd1, 1'b0);
        send_word(12'd7, 32'd1, 1'b0);
        send_read(12'd7, 6'd1);
        // window equal to the history depth, long sentence
        write_window(4'd15);
        for (int i = 0; i < 18; i++) send_word(12'd9, 32'd2, i == 0);
        send_read(12'd9, 6'd2);

        // heavy accumulation on one cell with window 15
        for (int i = 0; i < 60; i++) begin
            send_item(wcc_pkg::OP_WORD, {20'd0, 32'd3, 12'd3});
            if (i % 20 == 0) send_read(12'd3, 6'd3);
        end
        send_read(12'd3, 6'd3);

        send_idle_pct = 0;  recv_stall_pct = 0;  random_phase(230, 4'd1);
        send_idle_pct = 45; recv_stall_pct = 0;  random_phase(230, 4'd5);
        send_idle_pct = 0;  recv_stall_pct = 45; random_phase(230, 4'd15);
        send_idle_pct = 29; recv_stall_pct = 29; random_phase(230, 4'd3);
        send_idle_pct = 0;  recv_stall_pct = 0;  random_phase(80, 4'd8);

        wait_quiet();
        $display("Covered %0d word transfers and %0d count reads, %0d results checked.",
                 words_sent, reads_sent, sb.reads_checked);
        $display("Window sizes 0, 1, 3, 5, 8 and 15 with sender and receiver stalls.");
        if (sb.errors == 0 && sb.pending_counts.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // the clearing pass alone is about 1 ms; limit is generous
    initial begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
